// File: design/sexp_tok_pkg.sv
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Token kinds, character codes, keyword table and the result word type
// shared by the s-expression tokenizer.
// ----------------------------------------------------------------------------
package sexp_tok_pkg;

	localparam logic [3:0] KIND_OPEN     = 4'd0;
	localparam logic [3:0] KIND_CLOSE    = 4'd1;
	localparam logic [3:0] KIND_NUMBER   = 4'd2;
	localparam logic [3:0] KIND_KEYWORD  = 4'd3;
	localparam logic [3:0] KIND_VARIABLE = 4'd4;
	localparam logic [3:0] KIND_ADD      = 4'd5;
	localparam logic [3:0] KIND_SUB      = 4'd6;
	localparam logic [3:0] KIND_DIV      = 4'd7;
	localparam logic [3:0] KIND_MUL      = 4'd8;
	localparam logic [3:0] KIND_ERROR    = 4'd9;
	localparam logic [3:0] KIND_END      = 4'd10;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_NUM  = 2'd1;
	localparam logic [1:0] PEND_WORD = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_ADD   = 8'h2b;
	localparam logic [7:0] CH_SUB   = 8'h2d;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_DIGIT_LO = 8'd48;
	localparam logic [7:0] CH_DIGIT_HI = 8'd57;
	localparam logic [7:0] CH_LOWER_LO = 8'd97;
	localparam logic [7:0] CH_LOWER_HI = 8'd122;

	localparam int KW_SLOTS = 8;

	localparam logic [3:0] KW_LEN [0:KW_SLOTS-1] = '{
		4'd3, 4'd8, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	localparam logic [7:0] KW_TEXT [0:KW_SLOTS-1][0:7] = '{
		'{"a", "d", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "u", "b", "t", "r", "a", "c", "t"},
		'{"s", "e", "t", "q", 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  kw_index;
		logic        last;
	} result_t;

endpackage

// File: design/s_expression_tokenizer.sv
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// Splits a character stream into brackets, operators, numbers, keywords and
// variables (plus error and end words), one character per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Input channel ch_valid/ch_ready carries one character and end_of_source.
// Output channel token_valid/token_ready carries one token word: kind, start,
// length, keyword_index and last (set on the final word of a source).
// A character is classified against the tokenizer state and the keyword
// table in the cycle it is accepted; its words (zero, one or two) are written
// into a four-entry result queue at that edge and are presented on the output
// in order from the queue head.
// Throughput is one character per cycle while the queue has room for two
// words; ch_ready drops when fewer than two entries are free, so a stalled
// receiver holds the input back after at most three or four queued words.
// A character that ends a pending token and is itself a token gives two
// words, which drain at one per cycle while token_ready is high.
// Reset empties the queue and clears position, pending token and error flag.
// ----------------------------------------------------------------------------
module s_expression_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ch_valid,
	output logic        ch_ready,
	input  logic [7:0]  ch,
	input  logic        end_of_source,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [1:0]  keyword_index,
	output logic        last
);
	import sexp_tok_pkg::*;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [KEYWORD_COUNT-1:0] mask_t;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	function automatic pos_t sat_inc(input pos_t v);
		pos_t r;
		r = (v == '1) ? v : v + pos_t'(1);
		return r;
	endfunction

	function automatic mask_t word_step(input mask_t m, input pos_t len,
		input logic [7:0] c);
		mask_t r;
		r = '0;
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			if (m[i] && (len < pos_t'(KW_LEN[i])) && (KW_TEXT[i][len[2:0]] == c))
				r[i] = 1'b1;
		end
		return r;
	endfunction

	function automatic result_t flush_word(input logic [1:0] pk, input pos_t ps,
		input pos_t pl, input mask_t m);
		result_t r;
		logic    found;
		r = '0;
		found = 1'b0;
		r.start = 16'(ps);
		r.length = 16'(pl);
		if (pk == PEND_NUM) begin
			r.kind = KIND_NUMBER;
		end else begin
			r.kind = KIND_VARIABLE;
			for (int i = 0; i < KEYWORD_COUNT; i++) begin
				if (!found && m[i] && (pl == pos_t'(KW_LEN[i]))) begin
					found = 1'b1;
					r.kind = KIND_KEYWORD;
					r.kw_index = 2'(i);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_OPEN:  k = KIND_OPEN;
			CH_CLOSE: k = KIND_CLOSE;
			CH_ADD:   k = KIND_ADD;
			CH_SUB:   k = KIND_SUB;
			CH_DIV:   k = KIND_DIV;
			CH_MUL:   k = KIND_MUL;
			default:  k = KIND_ERROR;
		endcase
		return k;
	endfunction

	logic [1:0] pk_q, pk_n;
	pos_t       ps_q, ps_n;
	pos_t       pl_q, pl_n;
	pos_t       pos_q, pos_n;
	mask_t      mask_q, mask_n;
	logic       err_q, err_n;

	result_t    res [2];
	result_t    tok;
	logic [1:0] n;
	logic       is_dig, is_low;

	result_t    fifo_q [DEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [CW-1:0] count_q;
	logic       push, pop;

	assign is_dig = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);
	assign is_low = (ch >= CH_LOWER_LO) && (ch <= CH_LOWER_HI);

	always_comb begin
		res[0] = '0;
		res[1] = '0;
		tok = '0;
		n = 2'd0;
		pk_n = pk_q;
		ps_n = ps_q;
		pl_n = pl_q;
		pos_n = pos_q;
		mask_n = mask_q;
		err_n = err_q;
		if (!err_q) begin
			if ((pk_q == PEND_NUM) && is_dig) begin
				pl_n = sat_inc(pl_q);
			end else if ((pk_q == PEND_WORD) && (is_dig || is_low)) begin
				mask_n = word_step(mask_q, pl_q, ch);
				pl_n = sat_inc(pl_q);
			end else begin
				if ((pk_q == PEND_NUM) || (pk_q == PEND_WORD)) begin
					res[0] = flush_word(pk_q, ps_q, pl_q, mask_q);
					n = 2'd1;
				end
				pk_n = PEND_NONE;
				ps_n = '0;
				pl_n = '0;
				mask_n = '1;
				if (is_dig) begin
					pk_n = PEND_NUM;
					ps_n = pos_q;
					pl_n = pos_t'(1);
				end else if (is_low) begin
					pk_n = PEND_WORD;
					ps_n = pos_q;
					pl_n = pos_t'(1);
					mask_n = word_step('1, '0, ch);
				end else if (ch != CH_SPACE) begin
					tok.kind = single_kind(ch);
					tok.start = 16'(pos_q);
					tok.length = 16'd1;
					res[n[0]] = tok;
					n = n + 2'd1;
					if (tok.kind == KIND_ERROR)
						err_n = 1'b1;
				end
			end
		end
		if (end_of_source) begin
			if (!err_n && ((pk_n == PEND_NUM) || (pk_n == PEND_WORD))) begin
				res[n[0]] = flush_word(pk_n, ps_n, pl_n, mask_n);
				n = n + 2'd1;
			end
			if (n == 2'd0) begin
				res[0].kind = KIND_END;
				res[0].start = 16'(pos_q);
				n = 2'd1;
			end
			res[n[1]].last = 1'b1;
			pk_n = PEND_NONE;
			ps_n = '0;
			pl_n = '0;
			mask_n = '1;
			pos_n = '0;
			err_n = 1'b0;
		end else begin
			pos_n = sat_inc(pos_q);
		end
	end

	assign ch_ready    = (count_q <= CW'(DEPTH - 2));
	assign push        = ch_valid && ch_ready;
	assign token_valid = (count_q != '0);
	assign pop         = token_valid && token_ready;

	assign token_kind    = fifo_q[rd_q].kind;
	assign token_start   = fifo_q[rd_q].start;
	assign token_length  = fifo_q[rd_q].length;
	assign keyword_index = fifo_q[rd_q].kw_index;
	assign last          = fifo_q[rd_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_q <= PEND_NONE;
			ps_q <= '0;
			pl_q <= '0;
			pos_q <= '0;
			mask_q <= '1;
			err_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				pk_q <= pk_n;
				ps_q <= ps_n;
				pl_q <= pl_n;
				pos_q <= pos_n;
				mask_q <= mask_n;
				err_q <= err_n;
				wr_q <= wr_q + AW'(n);
			end
			if (pop)
				rd_q <= rd_q + AW'(1);
			count_q <= count_q + (push ? CW'(n) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			if (n != 2'd0)
				fifo_q[wr_q] <= res[0];
			if (n == 2'd2)
				fifo_q[wr_q + AW'(1)] <= res[1];
		end
	end

endmodule
